// ===== src/tpsb_pkg.sv =====
// Shared constants, types and helpers for the turning-point state bit table.
package tpsb_pkg;

   // Table geometry.
   localparam int NUM_SLOTS  = 4;
   localparam int LIST_DEPTH = 8;
   localparam int BATCH      = 2;

   // Field widths fixed by the item format.
   localparam int SLOT_W  = 2;
   localparam int POINT_W = 16;
   localparam int BIT_W   = 2;
   localparam int CNT4_W  = 4;

   // Derived widths.
   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   // State bit codes in 2-bit two's complement.
   localparam logic [BIT_W-1:0] BIT_POS  = 2'b01;
   localparam logic [BIT_W-1:0] BIT_NEG  = 2'b11;
   localparam logic [BIT_W-1:0] BIT_ZERO = 2'b00;

   // Rounding to a multiple of the batch size.
   localparam bit BATCH_POW2 = ((BATCH & (BATCH - 1)) == 0);
   localparam logic [32:0] BATCH_RECIP = 33'(((64'd1 << 32) + 64'(BATCH) - 64'd1) / 64'(BATCH));
   localparam logic [POINT_W-1:0] BATCH_MASK = POINT_W'(BATCH - 1);

   // Slot, point and offset broadcast from the control logic to every cell of the chain.
   typedef struct packed {
      logic [SLOT_IDX_W-1:0] slot_idx;
      logic [POINT_W-1:0]    point;
      logic [POINT_W-1:0]    offset;
   } tpsb_cmd_type;

   // Compare results that each cell reports back.
   typedef struct packed {
      logic lt;
      logic eq;
   } tpsb_stat_type;

   // Round a value count down to a multiple of the batch size.
   function automatic logic [POINT_W-1:0] round_point(input logic [POINT_W-1:0] vc);
      logic [48:0]        prod;
      logic [POINT_W-1:0] quot;
      if (BATCH_POW2) begin
         return vc & ~BATCH_MASK;
      end
      prod = {33'b0, vc} * {16'b0, BATCH_RECIP};
      quot = prod[47:32];
      return POINT_W'(32'(quot) * BATCH);
   endfunction

   // Present a list count on the 4-bit result field.
   function automatic logic [CNT4_W-1:0] to_count4(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+CNT4_W-1:0] ext;
      ext = {{CNT4_W{1'b0}}, cnt};
      return ext[CNT4_W-1:0];
   endfunction

endpackage

// ===== src/tpsb_cell.sv =====
// One position of the sorted turning-point lists, holding that position for every slot.
module tpsb_cell import tpsb_pkg::*; (
   input  logic                clock,
   input  tpsb_cmd_type        cmd,
   input  logic                ins_en,
   input  logic                rm_en,
   input  logic                entry_valid,
   input  logic [POINT_W-1:0]  prev_point,
   input  logic                prev_lt,
   input  logic [POINT_W-1:0]  next_point,
   input  logic                parity_in,
   output logic [POINT_W-1:0]  cur_point,
   output tpsb_stat_type       stat,
   output logic                parity_out
);

   logic [POINT_W-1:0] pt_ff [NUM_SLOTS];
   logic [POINT_W-1:0] pt_in;
   logic               wr_en;
   logic               le;

   // Read the entry of the addressed slot.
   assign cur_point = pt_ff[cmd.slot_idx];

   // Compare against the flip point and the query offset.
   always_comb begin
      stat.lt = entry_valid && (cur_point < cmd.point);
      stat.eq = entry_valid && (cur_point == cmd.point);
      le      = entry_valid && (cur_point <= cmd.offset);
   end

   // The query parity is handed down the chain.
   assign parity_out = parity_in ^ le;

   // Insert takes the new point at its sorted place and shifts the tail right;
   // removal shifts the tail left over the matching entry.
   always_comb begin
      wr_en = 1'b0;
      pt_in = cur_point;
      if (ins_en && !stat.lt) begin
         wr_en = 1'b1;
         pt_in = prev_lt ? cmd.point : prev_point;
      end else if (rm_en && !stat.lt) begin
         wr_en = 1'b1;
         pt_in = next_point;
      end
   end

   // Entry storage, written for the addressed slot only.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pt_ff[cmd.slot_idx] <= pt_in;
      end
   end

endmodule

// ===== src/turning_point_state_bit_table_core.sv =====
// Top level of the turning-point state bit table: slot state, cell chain and result register.
//
// Every slot keeps a base state bit and a sorted list of turning points spread across a
// chain of LIST_DEPTH cells, one list position per cell. For each item, all cells
// compare the addressed slot's entries at once, a flip shifts the list tail by one cell
// toward its neighbor, and a query passes a parity bit down the chain. The result sits in an
// output register, so a new beat is accepted every cycle while the result side keeps up;
// the request side stalls only while a finished result waits to be taken. The point lists
// have no reset; only entries below a slot's count are ever used.
module turning_point_state_bit_table_core import tpsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] slot, [2] fixed_slot, [18:3] offset, [34:19] value_count, [39:35] zero
   input  logic [39:0] req_tdata,
   // [0] mode
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] bit_value, [5:2] point_count, [6] overflow, [7] zero
   output logic [7:0]  rsp_tdata
);

   // Request fields.
   logic                  mode;
   logic [SLOT_W-1:0]     slot;
   logic                  fixed_slot;
   logic [POINT_W-1:0]    offset;
   logic [POINT_W-1:0]    value_count;
   logic                  accept;
   logic                  slot_ok;
   logic [SLOT_IDX_W+SLOT_W-1:0] slot_ext;
   logic [SLOT_IDX_W-1:0] idx;

   // Slot state.
   logic                  neg_ff   [NUM_SLOTS];
   logic [CNT_W-1:0]      total_ff [NUM_SLOTS];
   logic [CNT_W-1:0]      total;

   // Chain wiring.
   tpsb_cmd_type          cmd;
   logic                  ins_en;
   logic                  rm_en;
   tpsb_stat_type         stat    [LIST_DEPTH];
   logic [POINT_W-1:0]    cur_pt  [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] ent_valid;
   logic [LIST_DEPTH-1:0] eq_vec;
   logic [LIST_DEPTH:0]   parity;
   logic                  found;
   logic                  full;

   // Result register.
   logic                  rsp_valid_ff;
   logic [BIT_W-1:0]      bit_ff;
   logic [CNT4_W-1:0]     cnt_ff;
   logic                  ovf_ff;
   logic [BIT_W-1:0]      bit_in;
   logic [CNT4_W-1:0]     cnt_in;
   logic                  ovf_in;
   logic [CNT_W-1:0]      total_in;

   // Unpack the request beat.
   assign mode        = req_tuser[0];
   assign slot        = req_tdata[1:0];
   assign fixed_slot  = req_tdata[2];
   assign offset      = req_tdata[18:3];
   assign value_count = req_tdata[34:19];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Slot decode; slots past the table answer zeros and change nothing.
   assign slot_ok  = (32'(slot) < NUM_SLOTS);
   assign slot_ext = {{SLOT_IDX_W{1'b0}}, slot};
   assign idx      = slot_ext[SLOT_IDX_W-1:0];
   assign total    = total_ff[idx];

   // Command broadcast to the cells.
   always_comb begin
      cmd.slot_idx = idx;
      cmd.point    = round_point(value_count);
      cmd.offset   = offset;
   end

   // Insert and remove strobes, decided from the cells' compare results.
   assign ins_en = accept && mode && slot_ok && !found && !full;
   assign rm_en  = accept && mode && slot_ok && found;

   assign full      = (32'(total) >= LIST_DEPTH);
   assign parity[0] = 1'b0;

   // The cell chain.
   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [POINT_W-1:0] prev_point;
      logic               prev_lt;
      logic [POINT_W-1:0] next_point;

      assign ent_valid[i] = (32'(total) > i);
      assign eq_vec[i]    = stat[i].eq;

      if (i == 0) begin : g_head
         assign prev_point = '0;
         assign prev_lt    = 1'b1;
      end else begin : g_body
         assign prev_point = cur_pt[i-1];
         assign prev_lt    = stat[i-1].lt;
      end

      if (i == LIST_DEPTH - 1) begin : g_tail
         assign next_point = '0;
      end else begin : g_inner
         assign next_point = cur_pt[i+1];
      end

      tpsb_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .ins_en      (ins_en),
         .rm_en       (rm_en),
         .entry_valid (ent_valid[i]),
         .prev_point  (prev_point),
         .prev_lt     (prev_lt),
         .next_point  (next_point),
         .parity_in   (parity[i]),
         .cur_point   (cur_pt[i]),
         .stat        (stat[i]),
         .parity_out  (parity[i+1])
      );
   end

   assign found = |eq_vec;

   // Result of the current beat and the slot's next count.
   always_comb begin
      bit_in   = BIT_ZERO;
      ovf_in   = 1'b0;
      total_in = total;
      if (ins_en) begin
         total_in = total + CNT_W'(1);
      end else if (rm_en) begin
         total_in = total - CNT_W'(1);
      end
      if (slot_ok) begin
         if (mode) begin
            bit_in = neg_ff[idx] ? BIT_POS : BIT_NEG;
            ovf_in = !found && full;
         end else if (!fixed_slot) begin
            bit_in = (neg_ff[idx] ^ parity[LIST_DEPTH]) ? BIT_NEG : BIT_POS;
         end
         cnt_in = to_count4(total_in);
      end else begin
         cnt_in = '0;
      end
   end

   // Base bits and counts per slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            neg_ff[s]   <= 1'b0;
            total_ff[s] <= '0;
         end
      end else if (accept && mode && slot_ok) begin
         neg_ff[idx]   <= !neg_ff[idx];
         total_ff[idx] <= total_in;
      end
   end

   // Output register: valid has reset, payload has none.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         bit_ff <= bit_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, ovf_ff, cnt_ff, bit_ff};

   // An overflow is only reported against a full list.
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ovf_ff) |-> (cnt_ff == to_count4(CNT_W'(LIST_DEPTH))))
      else $error("overflow reported on a list that is not full");

   // Slot 0's list never grows past its depth.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(total_ff[0]) <= LIST_DEPTH))
      else $error("slot 0 point count exceeds list depth");

   // A flip always negates the addressed slot's base bit.
   a_flip_negates: assert property (@(posedge clock) disable iff (reset)
      (accept && mode && slot_ok) |=> (neg_ff[$past(idx)] != $past(neg_ff[idx])))
      else $error("flip did not negate the base bit");

   // Insert and remove never fire together.
   a_ins_rm_excl: assert property (@(posedge clock) disable iff (reset)
      !(ins_en && rm_en))
      else $error("insert and remove issued in the same cycle");

endmodule
